[rtl/stfd_pkg.sv]
// ----------------------------------------------------------------------------
// stfd_pkg: shared types, constants and helpers
// Sample formats, ring geometry, register map, control/status bundles and
// saturation helpers for the stereo tap feedback delay.
// ----------------------------------------------------------------------------
package stfd_pkg;

	localparam int SAMPLE_BITS    = 24;
	localparam int WIDE_BITS      = SAMPLE_BITS + 8;
	localparam int RING_DEPTH     = 32768;              // power of two
	localparam int RING_AW        = $clog2(RING_DEPTH);
	localparam int FILL_BITS      = RING_AW + 1;
	localparam int DELAY_BITS     = 15;
	localparam int GAIN_BITS      = 16;
	localparam int CFG_DATA_BITS  = 16;
	localparam int CFG_INDEX_BITS = 3;

	localparam logic [DELAY_BITS-1:0] DELAY_RESET = DELAY_BITS'(10880);

	localparam logic signed [16:0] BLK_IN_COEF    = 17'sd65408;
	localparam logic signed [10:0] BLK_STATE_COEF = -11'sd257;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_CENTRE_DELAY   = 3'd0,
		REG_LEFT_DELAY     = 3'd1,
		REG_RIGHT_DELAY    = 3'd2,
		REG_CENTRE_GAIN    = 3'd3,
		REG_LEFT_GAIN      = 3'd4,
		REG_RIGHT_GAIN     = 3'd5,
		REG_FEEDBACK_GAIN  = 3'd6,
		REG_PREFILTER_COEF = 3'd7
	} reg_index_t;

	typedef enum logic [1:0] {
		TAP_CENTRE = 2'd0,
		TAP_LEFT   = 2'd1,
		TAP_RIGHT  = 2'd2
	} tap_sel_t;

	typedef struct packed {
		logic [DELAY_BITS-1:0] centre_delay;
		logic [DELAY_BITS-1:0] left_delay;
		logic [DELAY_BITS-1:0] right_delay;
		logic [GAIN_BITS-1:0]  centre_amp;
		logic [GAIN_BITS-1:0]  left_amp;
		logic [GAIN_BITS-1:0]  right_amp;
		logic [GAIN_BITS-1:0]  feedback_gain;   // signed Q1.15
		logic [GAIN_BITS-1:0]  prefilter_coef;
	} cfg_t;

	typedef struct packed {
		logic     ld_in;
		logic     do_blk;
		logic     do_filt;
		logic     do_wr;
		logic     rd_en;
		tap_sel_t rd_sel;
		logic     lat_c;
		logic     lat_l;
		logic     do_mul;
		logic     do_sum;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} stat_t;

	function automatic logic signed [WIDE_BITS-1:0] sat_wide(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (WIDE_BITS - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (v > hi)
			return WIDE_BITS'(hi);
		else if (v < lo)
			return WIDE_BITS'(lo);
		else
			return WIDE_BITS'(v);
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (v > hi)
			return SAMPLE_BITS'(hi);
		else if (v < lo)
			return SAMPLE_BITS'(lo);
		else
			return SAMPLE_BITS'(v);
	endfunction

	// delay modulo ring depth
	function automatic logic [RING_AW-1:0] tap_offset(input logic [DELAY_BITS-1:0] d);
		logic [31:0] w;
		w = 32'(d);
		return w[RING_AW-1:0];
	endfunction

endpackage

[rtl/stfd_regs.sv]
// ----------------------------------------------------------------------------
// stfd_regs: configuration register file
// Write-only registers, one per index, with their reset values.
// ----------------------------------------------------------------------------
module stfd_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 wr_en,
	input  logic [stfd_pkg::CFG_INDEX_BITS-1:0]  wr_index,
	input  logic [stfd_pkg::CFG_DATA_BITS-1:0]   wr_data,
	output stfd_pkg::cfg_t                       cfg
);

	stfd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.centre_delay   <= stfd_pkg::DELAY_RESET;
			cfg_q.left_delay     <= stfd_pkg::DELAY_RESET;
			cfg_q.right_delay    <= stfd_pkg::DELAY_RESET;
			cfg_q.centre_amp     <= '0;
			cfg_q.left_amp       <= '0;
			cfg_q.right_amp      <= '0;
			cfg_q.feedback_gain  <= '0;
			cfg_q.prefilter_coef <= '0;
		end else if (wr_en) begin
			unique case (stfd_pkg::reg_index_t'(wr_index))
				stfd_pkg::REG_CENTRE_DELAY:
					cfg_q.centre_delay <= wr_data[stfd_pkg::DELAY_BITS-1:0];
				stfd_pkg::REG_LEFT_DELAY:
					cfg_q.left_delay <= wr_data[stfd_pkg::DELAY_BITS-1:0];
				stfd_pkg::REG_RIGHT_DELAY:
					cfg_q.right_delay <= wr_data[stfd_pkg::DELAY_BITS-1:0];
				stfd_pkg::REG_CENTRE_GAIN:
					cfg_q.centre_amp <= wr_data[stfd_pkg::GAIN_BITS-1:0];
				stfd_pkg::REG_LEFT_GAIN:
					cfg_q.left_amp <= wr_data[stfd_pkg::GAIN_BITS-1:0];
				stfd_pkg::REG_RIGHT_GAIN:
					cfg_q.right_amp <= wr_data[stfd_pkg::GAIN_BITS-1:0];
				stfd_pkg::REG_FEEDBACK_GAIN:
					cfg_q.feedback_gain <= wr_data[stfd_pkg::GAIN_BITS-1:0];
				stfd_pkg::REG_PREFILTER_COEF:
					cfg_q.prefilter_coef <= wr_data[stfd_pkg::GAIN_BITS-1:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/stfd_ctrl.sv]
// ----------------------------------------------------------------------------
// stfd_ctrl: item sequencer
// Steps one word through conditioning, ring write, three tap reads,
// gain products and the output sum.
// ----------------------------------------------------------------------------
module stfd_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  stfd_pkg::stat_t      stat,
	output stfd_pkg::cmd_t       cmd
);

	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_BLK  = 9'b000000010,
		ST_FILT = 9'b000000100,
		ST_WR   = 9'b000001000,
		ST_RDC  = 9'b000010000,
		ST_RDL  = 9'b000100000,
		ST_RDR  = 9'b001000000,
		ST_MUL  = 9'b010000000,
		ST_SUM  = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.rd_sel = stfd_pkg::TAP_CENTRE;
		in_ready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.ld_in = in_valid;
				if (in_valid)
					state_d = ST_BLK;
			end
			ST_BLK: begin
				cmd.do_blk = 1'b1;
				state_d    = ST_FILT;
			end
			ST_FILT: begin
				cmd.do_filt = 1'b1;
				state_d     = ST_WR;
			end
			ST_WR: begin
				cmd.do_wr = 1'b1;
				state_d   = ST_RDC;
			end
			ST_RDC: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = stfd_pkg::TAP_CENTRE;
				state_d    = ST_RDL;
			end
			ST_RDL: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = stfd_pkg::TAP_LEFT;
				cmd.lat_c  = 1'b1;
				state_d    = ST_RDR;
			end
			ST_RDR: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = stfd_pkg::TAP_RIGHT;
				cmd.lat_l  = 1'b1;
				state_d    = ST_MUL;
			end
			ST_MUL: begin
				cmd.do_mul = 1'b1;
				state_d    = ST_SUM;
			end
			ST_SUM: begin
				cmd.do_sum = !stat.out_busy;
				if (!stat.out_busy)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

[rtl/stfd_datapath.sv]
// ----------------------------------------------------------------------------
// stfd_datapath: filters, delay ring and tap mixing
// DC blocker, optional one-pole lowpass, feedback write into a single-port
// ring, masked tap reads, gain products and saturated output register.
// ----------------------------------------------------------------------------
module stfd_datapath (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  stfd_pkg::cfg_t                          cfg,
	input  stfd_pkg::cmd_t                          cmd,
	output stfd_pkg::stat_t                         stat,
	input  logic signed [stfd_pkg::SAMPLE_BITS-1:0] send_sample,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [stfd_pkg::SAMPLE_BITS-1:0] left_sample,
	output logic signed [stfd_pkg::SAMPLE_BITS-1:0] right_sample
);

	localparam int SB = stfd_pkg::SAMPLE_BITS;
	localparam int WB = stfd_pkg::WIDE_BITS;
	localparam int AW = stfd_pkg::RING_AW;
	localparam int FB = stfd_pkg::FILL_BITS;

	// ring memory, no reset; unwritten entries masked by fill count
	logic [SB-1:0] ring_mem [stfd_pkg::RING_DEPTH];
	logic [SB-1:0] rd_q;
	logic          rd_ok_q;

	logic signed [SB-1:0] send_q;
	logic signed [WB-1:0] y_q;
	logic signed [WB-1:0] v_q;
	logic signed [WB-1:0] bs_q;
	logic signed [WB-1:0] pf_q;
	logic signed [SB-1:0] held_q;
	logic signed [SB-1:0] c_q;
	logic signed [SB-1:0] l_q;
	logic signed [SB+15:0] fbp_q;
	logic signed [SB+16:0] pl_q;
	logic signed [SB+16:0] pr_q;
	logic signed [SB+16:0] pc_q;
	logic signed [SB-1:0] left_q;
	logic signed [SB-1:0] right_q;
	logic                 out_valid_q;
	logic [AW-1:0]        wp_q;
	logic [FB-1:0]        fill_q;

	logic signed [WB-1:0]    x_wide;
	logic signed [WB+16:0]   prod_blk;
	logic signed [WB-1:0]    y_next;
	logic signed [WB+10:0]   prod_bs;
	logic signed [WB-1:0]    bs_next;
	logic [16:0]             coef_inv;
	logic signed [WB+16:0]   prod_pc;
	logic signed [WB+17:0]   prod_yc;
	logic signed [WB-1:0]    pf_next;
	logic                    pf_on;
	logic signed [63:0]      wr_acc;
	logic signed [SB-1:0]    wr_data_s;
	logic [AW-1:0]           rd_off;
	logic [AW-1:0]           rd_addr;
	logic signed [SB-1:0]    tap_val;

	assign x_wide   = {send_q, 8'b0};
	assign prod_blk = x_wide * stfd_pkg::BLK_IN_COEF;
	assign y_next   = stfd_pkg::sat_wide(64'(prod_blk >>> 16) + 64'(bs_q));

	assign prod_bs  = y_q * stfd_pkg::BLK_STATE_COEF;
	assign bs_next  = stfd_pkg::sat_wide(64'(bs_q) + 64'(prod_bs >>> 16));

	assign pf_on    = (cfg.prefilter_coef != '0);
	assign coef_inv = 17'h10000 - {1'b0, cfg.prefilter_coef};
	assign prod_pc  = pf_q * $signed({1'b0, cfg.prefilter_coef});
	assign prod_yc  = y_q * $signed({1'b0, coef_inv});
	assign pf_next  = stfd_pkg::sat_wide((64'(prod_pc) + 64'(prod_yc)) >>> 16);

	assign wr_acc    = (64'(v_q) <<< 15) + (64'(fbp_q) <<< 8);
	assign wr_data_s = stfd_pkg::sat_sample(wr_acc >>> 23);

	always_comb begin
		unique case (cmd.rd_sel)
			stfd_pkg::TAP_CENTRE: rd_off = stfd_pkg::tap_offset(cfg.centre_delay);
			stfd_pkg::TAP_LEFT:   rd_off = stfd_pkg::tap_offset(cfg.left_delay);
			stfd_pkg::TAP_RIGHT:  rd_off = stfd_pkg::tap_offset(cfg.right_delay);
			default:              rd_off = '0;
		endcase
	end

	assign rd_addr = wp_q - rd_off;
	assign tap_val = rd_ok_q ? $signed(rd_q) : '0;

	always_ff @(posedge clk) begin
		if (cmd.do_wr)
			ring_mem[wp_q] <= wr_data_s;
		if (cmd.rd_en)
			rd_q <= ring_mem[rd_addr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.ld_in)
			send_q <= send_sample;
		if (cmd.do_blk) begin
			y_q   <= y_next;
			fbp_q <= $signed(cfg.feedback_gain) * held_q;
		end
		if (cmd.do_filt)
			v_q <= pf_on ? pf_next : y_q;
		if (cmd.lat_c)
			c_q <= tap_val;
		if (cmd.lat_l)
			l_q <= tap_val;
		if (cmd.do_mul) begin
			pl_q <= $signed({1'b0, cfg.left_amp}) * l_q;
			pr_q <= $signed({1'b0, cfg.right_amp}) * tap_val;
			pc_q <= $signed({1'b0, cfg.centre_amp}) * c_q;
		end
		if (cmd.do_sum) begin
			left_q  <= stfd_pkg::sat_sample((64'(pl_q) + 64'(pc_q)) >>> 16);
			right_q <= stfd_pkg::sat_sample((64'(pr_q) + 64'(pc_q)) >>> 16);
		end
	end

	// filter and ring state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q        <= '0;
			pf_q        <= '0;
			held_q      <= '0;
			rd_ok_q     <= 1'b0;
			wp_q        <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.do_filt) begin
				bs_q <= bs_next;
				if (pf_on)
					pf_q <= pf_next;
			end
			if (cmd.rd_en)
				rd_ok_q <= ({1'b0, rd_off} <= fill_q);
			if (cmd.lat_c)
				held_q <= tap_val;
			if (cmd.do_sum) begin
				wp_q <= wp_q + AW'(1);
				if (fill_q != FB'(stfd_pkg::RING_DEPTH))
					fill_q <= fill_q + FB'(1);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.out_busy = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign left_sample   = left_q;
	assign right_sample  = right_q;

`ifndef SYNTHESIS
	a_sum_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_sum |-> !(out_valid_q && !out_ready))
		else $error("result overwrote an untaken word");
	a_sum_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_sum |=> out_valid_q && (wp_q == $past(wp_q) + AW'(1)))
		else $error("sum step did not present result and advance ring");
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_wr |-> !cmd.rd_en)
		else $error("ring write and read in same cycle");
	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FB'(stfd_pkg::RING_DEPTH))
		else $error("fill count beyond ring depth");
`endif

endmodule

[rtl/stereo_tap_feedback_delay_core.sv]
// ----------------------------------------------------------------------------
// stereo_tap_feedback_delay_core: stereo multitap feedback delay
// Mono send in, stereo wet pair out, with DC blocking, optional lowpass and
// a centre-tap feedback path through a single-port delay ring.
//
//   channel   handshake               payload
//   in        in_valid / in_ready     send_sample
//   out       out_valid / out_ready   left_sample, right_sample
//   config    wr_en (no wait)         wr_index, wr_data
//
// A new word is taken only once the last one has passed its sum step: the
// sequencer walks the filters, one ring write and three tap reads on the
// single ring port, then the gain products and the sum.
// Reset needs no clearing pass: a fill count marks ring entries never written,
// which read as zero.
// A finished result sits in the output register; the next word is accepted
// meanwhile and waits at its sum step until that result is taken.
// ----------------------------------------------------------------------------
module stereo_tap_feedback_delay_core (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic signed [stfd_pkg::SAMPLE_BITS-1:0] send_sample,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [stfd_pkg::SAMPLE_BITS-1:0] left_sample,
	output logic signed [stfd_pkg::SAMPLE_BITS-1:0] right_sample,
	input  logic                                    wr_en,
	input  logic [stfd_pkg::CFG_INDEX_BITS-1:0]     wr_index,
	input  logic [stfd_pkg::CFG_DATA_BITS-1:0]      wr_data
);

	stfd_pkg::cfg_t  cfg;
	stfd_pkg::cmd_t  cmd;
	stfd_pkg::stat_t stat;

	stfd_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	stfd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	stfd_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.stat         (stat),
		.send_sample  (send_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.left_sample  (left_sample),
		.right_sample (right_sample)
	);

endmodule
